// File: rtl/fault_shunt_admittance_assert.svh
// Assertion macros shared by the fault shunt admittance RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef FAULT_SHUNT_ADMITTANCE_ASSERT_SVH
`define FAULT_SHUNT_ADMITTANCE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define FSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/fsa_pkg.sv
// Types and constants of the fault shunt admittance block.
// Used by fsa_front, fsa_back and the top level; depends on nothing.
`default_nettype none
package fsa_pkg;

	// Fault kinds.
	localparam logic [1:0] KIND_THREE_PHASE = 2'd0;
	localparam logic [1:0] KIND_LINE_GROUND = 2'd1;
	localparam logic [1:0] KIND_LINE_LINE   = 2'd2;
	localparam logic [1:0] KIND_DOUBLE_LG   = 2'd3;

	localparam int IW  = 48;   // input field width
	localparam int OPW = 51;   // classified operand width
	localparam int QW  = 102;  // equivalent impedance numerator width
	localparam int DW  = 204;  // squared magnitude width
	localparam int MW  = 154;  // numerator width before scaling
	localparam int RW  = 64;   // result width
	localparam int MUL_LAT = 4;

	localparam longint SAT_UNITS = 64'd100000000;
	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

	typedef logic signed [OPW-1:0] op_word_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic signed [IW-1:0]   thevenin_real;
		logic signed [IW-1:0]   thevenin_imag;
		logic signed [IW-1:0]   fault_real;
		logic signed [IW-1:0]   fault_imag;
	} in_item_t;

	typedef struct packed {
		logic signed [RW-1:0]   admittance_real;
		logic signed [RW-1:0]   admittance_imag;
		logic                   saturated;
	} out_item_t;

	// Y = D / Q with Q = t*z + f*p (complex), all operands classified up front.
	typedef struct packed {
		op_word_t t_r;
		op_word_t t_i;
		op_word_t z_r;
		op_word_t z_i;
		op_word_t f_r;
		op_word_t f_i;
		op_word_t p_r;
		op_word_t p_i;
		op_word_t d_r;
		op_word_t d_i;
		logic     psat;
	} op_t;

endpackage
`default_nettype wire

// File: rtl/fsa_fifo.sv
// Small register queue with a push/full and pop/empty interface.
// Item type is a parameter; depends on nothing else.
`default_nettype none
module fsa_fifo #(
	parameter type item_t = logic,
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/fsa_front.sv
// Front end: classifies a fault item into the operands of Y = D / (t*z + f*p).
// Depends on fsa_pkg.
`default_nettype none
module fsa_front (
	input  fsa_pkg::in_item_t request,
	output fsa_pkg::op_t      op
);
	fsa_pkg::op_word_t tr, ti, fr, fi, pr, pi, one;

	always_comb begin
		tr  = fsa_pkg::op_word_t'(request.thevenin_real);
		ti  = fsa_pkg::op_word_t'(request.thevenin_imag);
		fr  = fsa_pkg::op_word_t'(request.fault_real);
		fi  = fsa_pkg::op_word_t'(request.fault_imag);
		one = fsa_pkg::op_word_t'(1);
		pr  = (tr <<< 1) + (fr <<< 1) + fr;
		pi  = (ti <<< 1) + (fi <<< 1) + fi;

		// Simple kinds: Q = 1 * Zeq, D = 1.
		op      = '0;
		op.t_r  = one;
		op.d_r  = one;
		unique case (request.kind)
			fsa_pkg::KIND_THREE_PHASE: begin
				op.z_r = fr;
				op.z_i = fi;
			end
			fsa_pkg::KIND_LINE_GROUND: begin
				op.z_r = pr;
				op.z_i = pi;
			end
			fsa_pkg::KIND_LINE_LINE: begin
				op.z_r = tr + fr;
				op.z_i = ti + fi;
			end
			fsa_pkg::KIND_DOUBLE_LG: begin
				// Y = D / (Zth*(Zth+3Zf) + Zf*D), D = 2Zth+3Zf.
				op.t_r  = tr;
				op.t_i  = ti;
				op.z_r  = tr + (fr <<< 1) + fr;
				op.z_i  = ti + (fi <<< 1) + fi;
				op.f_r  = fr;
				op.f_i  = fi;
				op.p_r  = pr;
				op.p_i  = pi;
				op.d_r  = pr;
				op.d_i  = pi;
				op.psat = (pr == '0) && (pi == '0);
			end
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/fsa_mul.sv
// Four-stage signed multiplier built from 32x32 partial products.
// Depends on nothing.
`default_nettype none
module fsa_mul #(
	parameter int AW = 51,
	parameter int BW = 51
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	localparam int NA  = (AW + 31) / 32;
	localparam int NB  = (BW + 31) / 32;
	localparam int MAW = NA * 32;
	localparam int MBW = NB * 32;
	localparam int ROW = MAW + 32;
	localparam int TW  = MAW + MBW;
	localparam int PW  = AW + BW;

	logic [AW-1:0]  ua;
	logic [BW-1:0]  ub;
	logic [MAW-1:0] ma_s1;
	logic [MBW-1:0] mb_s1;
	logic           neg_s1, neg_s2, neg_s3;
	logic [63:0]    pp_s2 [NA][NB];
	logic [ROW-1:0] row_c [NB];
	logic [ROW-1:0] row_s3 [NB];
	logic [TW-1:0]  tot_c;
	logic signed [PW-1:0] p_s4;

	assign ua = a[AW-1] ? AW'(-a) : AW'(a);
	assign ub = b[BW-1] ? BW'(-b) : BW'(b);

	always_comb begin
		for (int j = 0; j < NB; j++) begin
			row_c[j] = '0;
			for (int i = 0; i < NA; i++) begin
				row_c[j] = row_c[j] + (ROW'(pp_s2[i][j]) << (32 * i));
			end
		end
		tot_c = '0;
		for (int j = 0; j < NB; j++) begin
			tot_c = tot_c + (TW'(row_s3[j]) << (32 * j));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= MAW'(ua);
			mb_s1  <= MBW'(ub);
			neg_s1 <= a[AW-1] ^ b[BW-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= 64'(ma_s1[32*i +: 32]) * 64'(mb_s1[32*j +: 32]);
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			p_s4   <= neg_s3 ? PW'(-tot_c) : PW'(tot_c);
		end
	end

	assign p = p_s4;
endmodule
`default_nettype wire

// File: rtl/fsa_back.sv
// Back end: complex products, squared magnitude, and a 64-stage pipelined
// restoring divider with rounding and clamping. Depends on fsa_pkg, fsa_mul.
`default_nettype none
`include "fault_shunt_admittance_assert.svh"
module fsa_back #(
	parameter int FRAC_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fsa_pkg::op_t       op,
	input  logic               op_valid,
	output logic               op_pop,
	output fsa_pkg::out_item_t res,
	output logic               res_push,
	input  logic               res_full
);
	localparam int OPW = fsa_pkg::OPW;
	localparam int QW  = fsa_pkg::QW;
	localparam int QSW = QW + 2;
	localparam int DW  = fsa_pkg::DW;
	localparam int MW  = fsa_pkg::MW;
	localparam int LAT = fsa_pkg::MUL_LAT;
	localparam int QB  = fsa_pkg::RW;
	localparam int NW  = MW + 2 * FRAC_BITS;
	localparam int DSW = DW + QB;
	localparam int CW  = ((NW > DSW) ? NW : DSW) + 1;
	localparam logic [127:0] SAT_WIDE = 128'(fsa_pkg::SAT_UNITS) << FRAC_BITS;
	localparam logic [63:0]  SAT_VAL  = (SAT_WIDE > 128'(fsa_pkg::POS_MAX)) ?
		fsa_pkg::POS_MAX : SAT_WIDE[63:0];

	logic adv;

	// First multiplier bank: Q = t*z + f*p.
	logic signed [OPW-1:0]     m1_a [8];
	logic signed [OPW-1:0]     m1_b [8];
	logic signed [2*OPW-1:0]   m1_p [8];
	logic [LAT-1:0]            m1_vld_q;
	logic [LAT-1:0]            m1_sat_q;
	logic signed [OPW-1:0]     m1_dr_q [LAT];
	logic signed [OPW-1:0]     m1_di_q [LAT];
	logic signed [QSW-1:0]     sum_r, sum_i;

	logic                      vld_s5, sat_s5;
	logic signed [QW-1:0]      q_r_s5, q_i_s5;
	logic signed [OPW-1:0]     d_r_s5, d_i_s5;

	// Second bank: |Q|^2 and D*conj(Q).
	logic signed [2*QW-1:0]    m2_sq [2];
	logic signed [OPW+QW-1:0]  m2_dq [4];
	logic [LAT-1:0]            m2_vld_q;
	logic [LAT-1:0]            m2_sat_q;

	logic                      vld_s10, sat_s10;
	logic [DW-1:0]             den_s10;
	logic signed [MW-1:0]      num_s10 [2];

	logic                      vld_s11, sat_s11;
	logic [DW-1:0]             den_s11;
	logic [MW-1:0]             mag_s11 [2];
	logic [1:0]                neg_s11;

	// Divider line; index 0 is the entry stage.
	logic [QB:0]               dv_vld_q;
	logic [QB:0]               dv_sat_q;
	logic [1:0]                dv_neg_q [QB+1];
	logic [1:0]                dv_ovf_q [QB+1];
	logic [DW-1:0]             dv_den_q [QB+1];
	logic [CW-1:0]             dv_rem_q [QB+1][2];
	logic [QB-1:0]             dv_quo_q [QB+1][2];
	logic [CW-1:0]             nrem_c   [QB][2];
	logic                      ge_c     [QB][2];
	logic [CW-1:0]             num_c    [2];
	logic [CW-1:0]             dsh_c;

	logic [QB:0]               q65_c [2];
	logic [QB-1:0]             lim_c [2];
	logic [QB-1:0]             val_c [2];
	logic                      fin_vld_q;
	fsa_pkg::out_item_t        fin_res_q;

	assign adv    = !res_full;
	assign op_pop = adv && op_valid;

	always_comb begin
		m1_a[0] = op.t_r; m1_b[0] = op.z_r;
		m1_a[1] = op.t_i; m1_b[1] = op.z_i;
		m1_a[2] = op.f_r; m1_b[2] = op.p_r;
		m1_a[3] = op.f_i; m1_b[3] = op.p_i;
		m1_a[4] = op.t_r; m1_b[4] = op.z_i;
		m1_a[5] = op.t_i; m1_b[5] = op.z_r;
		m1_a[6] = op.f_r; m1_b[6] = op.p_i;
		m1_a[7] = op.f_i; m1_b[7] = op.p_r;
	end

	for (genvar g = 0; g < 8; g++) begin : g_m1
		fsa_mul #(.AW(OPW), .BW(OPW)) u_mul (
			.clk(clk), .en(adv), .a(m1_a[g]), .b(m1_b[g]), .p(m1_p[g])
		);
	end

	always_comb begin
		sum_r = QSW'(m1_p[0]) - QSW'(m1_p[1]) + QSW'(m1_p[2]) - QSW'(m1_p[3]);
		sum_i = QSW'(m1_p[4]) + QSW'(m1_p[5]) + QSW'(m1_p[6]) + QSW'(m1_p[7]);
	end

	fsa_mul #(.AW(QW), .BW(QW)) u_sq_r (
		.clk(clk), .en(adv), .a(q_r_s5), .b(q_r_s5), .p(m2_sq[0])
	);
	fsa_mul #(.AW(QW), .BW(QW)) u_sq_i (
		.clk(clk), .en(adv), .a(q_i_s5), .b(q_i_s5), .p(m2_sq[1])
	);
	fsa_mul #(.AW(OPW), .BW(QW)) u_dq_rr (
		.clk(clk), .en(adv), .a(d_r_s5), .b(q_r_s5), .p(m2_dq[0])
	);
	fsa_mul #(.AW(OPW), .BW(QW)) u_dq_ii (
		.clk(clk), .en(adv), .a(d_i_s5), .b(q_i_s5), .p(m2_dq[1])
	);
	fsa_mul #(.AW(OPW), .BW(QW)) u_dq_ir (
		.clk(clk), .en(adv), .a(d_i_s5), .b(q_r_s5), .p(m2_dq[2])
	);
	fsa_mul #(.AW(OPW), .BW(QW)) u_dq_ri (
		.clk(clk), .en(adv), .a(d_r_s5), .b(q_i_s5), .p(m2_dq[3])
	);

	// Divider step: one quotient bit per stage, most significant first.
	always_comb begin
		dsh_c = CW'(den_s11) << QB;
		for (int c = 0; c < 2; c++) begin
			num_c[c] = CW'(mag_s11[c]) << (2 * FRAC_BITS);
		end
		for (int k = 0; k < QB; k++) begin
			for (int c = 0; c < 2; c++) begin
				ge_c[k][c]   = dv_rem_q[k][c] >= (CW'(dv_den_q[k]) << (QB - 1 - k));
				nrem_c[k][c] = ge_c[k][c] ?
					dv_rem_q[k][c] - (CW'(dv_den_q[k]) << (QB - 1 - k)) : dv_rem_q[k][c];
			end
		end
	end

	// Round half away from zero, then clamp to the signed 64-bit range.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			q65_c[c] = {1'b0, dv_quo_q[QB][c]} + (QB + 1)'(
				{dv_rem_q[QB][c][DW-1:0], 1'b0} >= {1'b0, dv_den_q[QB]});
			lim_c[c] = dv_neg_q[QB][c] ? fsa_pkg::NEG_MAX : fsa_pkg::POS_MAX;
			if (dv_ovf_q[QB][c] || (q65_c[c] > {1'b0, lim_c[c]})) begin
				val_c[c] = lim_c[c];
			end else begin
				val_c[c] = dv_neg_q[QB][c] ? -q65_c[c][QB-1:0] : q65_c[c][QB-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_vld_q  <= '0;
			vld_s5    <= 1'b0;
			m2_vld_q  <= '0;
			vld_s10   <= 1'b0;
			vld_s11   <= 1'b0;
			dv_vld_q  <= '0;
			fin_vld_q <= 1'b0;
		end else if (adv) begin
			m1_vld_q  <= {m1_vld_q[LAT-2:0], op_pop};
			vld_s5    <= m1_vld_q[LAT-1];
			m2_vld_q  <= {m2_vld_q[LAT-2:0], vld_s5};
			vld_s10   <= m2_vld_q[LAT-1];
			vld_s11   <= vld_s10;
			dv_vld_q  <= {dv_vld_q[QB-1:0], vld_s11};
			fin_vld_q <= dv_vld_q[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_dr_q[0] <= op.d_r;
			m1_di_q[0] <= op.d_i;
			m1_sat_q   <= {m1_sat_q[LAT-2:0], op.psat};
			for (int i = 1; i < LAT; i++) begin
				m1_dr_q[i] <= m1_dr_q[i-1];
				m1_di_q[i] <= m1_di_q[i-1];
			end

			q_r_s5 <= QW'(sum_r);
			q_i_s5 <= QW'(sum_i);
			d_r_s5 <= m1_dr_q[LAT-1];
			d_i_s5 <= m1_di_q[LAT-1];
			sat_s5 <= m1_sat_q[LAT-1] || ((sum_r == '0) && (sum_i == '0));

			m2_sat_q <= {m2_sat_q[LAT-2:0], sat_s5};

			den_s10    <= DW'(m2_sq[0] + m2_sq[1]);
			num_s10[0] <= MW'(m2_dq[0]) + MW'(m2_dq[1]);
			num_s10[1] <= MW'(m2_dq[2]) - MW'(m2_dq[3]);
			sat_s10    <= m2_sat_q[LAT-1];

			den_s11 <= den_s10;
			sat_s11 <= sat_s10;
			for (int c = 0; c < 2; c++) begin
				neg_s11[c] <= num_s10[c][MW-1];
				mag_s11[c] <= num_s10[c][MW-1] ? MW'(-num_s10[c]) : MW'(num_s10[c]);
			end

			dv_den_q[0] <= den_s11;
			dv_sat_q[0] <= sat_s11;
			dv_neg_q[0] <= neg_s11;
			for (int c = 0; c < 2; c++) begin
				dv_ovf_q[0][c] <= num_c[c] >= dsh_c;
				dv_rem_q[0][c] <= num_c[c];
				dv_quo_q[0][c] <= '0;
			end
			for (int k = 0; k < QB; k++) begin
				dv_den_q[k+1] <= dv_den_q[k];
				dv_sat_q[k+1] <= dv_sat_q[k];
				dv_neg_q[k+1] <= dv_neg_q[k];
				dv_ovf_q[k+1] <= dv_ovf_q[k];
				for (int c = 0; c < 2; c++) begin
					dv_rem_q[k+1][c] <= nrem_c[k][c];
					dv_quo_q[k+1][c] <= {dv_quo_q[k][c][QB-2:0], ge_c[k][c]};
				end
			end

			if (dv_sat_q[QB]) begin
				fin_res_q.admittance_real <= SAT_VAL;
				fin_res_q.admittance_imag <= '0;
				fin_res_q.saturated       <= 1'b1;
			end else begin
				fin_res_q.admittance_real <= val_c[0];
				fin_res_q.admittance_imag <= val_c[1];
				fin_res_q.saturated       <= 1'b0;
			end
		end
	end

	assign res      = fin_res_q;
	assign res_push = fin_vld_q && adv;

	`FSA_ASSERT_IMP(a_sat_imag_zero, clk, arst_n, fin_vld_q && fin_res_q.saturated, fin_res_q.admittance_imag == '0, "saturated item has nonzero susceptance")
	`FSA_ASSERT_NXT(a_hold_on_stall, clk, arst_n, !adv && fin_vld_q, fin_vld_q && $stable(fin_res_q), "finished item changed while output queue was full")
	`FSA_ASSERT_IMP(a_div_rem_bound, clk, arst_n, dv_vld_q[QB] && !dv_ovf_q[QB][0] && (dv_den_q[QB] != '0), dv_rem_q[QB][0] < CW'(dv_den_q[QB]), "divider remainder not below divisor")
endmodule
`default_nettype wire

// File: rtl/fault_shunt_admittance.sv
// Throughput: one item per cycle unless a full output queue stalls the pipeline.
// The pipelined divider (64 stages) sets the depth.
// Reset: arst_n clears all valid bits and queue pointers asynchronously.
// Payload registers carry no reset; the block is ready right after reset.
// Top level of the fault shunt admittance block; depends on fsa_pkg,
// fsa_fifo, fsa_front and fsa_back.
`default_nettype none
module fault_shunt_admittance #(
	parameter int FRAC_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  fsa_pkg::in_item_t  request,
	output logic               empty,
	input  logic               pop,
	output fsa_pkg::out_item_t result
);
	// The front end turns every fault kind into one common form,
	// Y = D / (t*z + f*p), so the back end needs no per-kind control.
	fsa_pkg::op_t       op_w;
	fsa_pkg::op_t       op_head;
	logic               op_empty;
	logic               op_pop;
	fsa_pkg::out_item_t res_w;
	logic               res_push;
	logic               res_full;

	fsa_front u_front (
		.request(request),
		.op(op_w)
	);

	// Short queue between front and back: an item is accepted into it
	// whenever it has room, independently of what the back end is doing.
	fsa_fifo #(.item_t(fsa_pkg::op_t), .DEPTH(4)) u_op_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(op_w), .full(full),
		.pop(op_pop), .rdata(op_head), .empty(op_empty)
	);

	// The back end advances as one pipeline whenever the output queue has
	// room; a full output queue holds every stage in place.
	fsa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.op(op_head), .op_valid(!op_empty), .op_pop(op_pop),
		.res(res_w), .res_push(res_push), .res_full(res_full)
	);

	// Output queue decouples the pipeline from the consumer's pop.
	fsa_fifo #(.item_t(fsa_pkg::out_item_t), .DEPTH(2)) u_res_queue (
		.clk(clk), .arst_n(arst_n),
		.push(res_push), .wdata(res_w), .full(res_full),
		.pop(pop), .rdata(result), .empty(empty)
	);
endmodule
`default_nettype wire

// File: tb/fault_shunt_admittance_tb.sv
// Self-checking testbench for the fault shunt admittance block.
// It runs directed and random impedance sets through the queue ports and checks each admittance.
// Depends on fsa_pkg and the fault_shunt_admittance RTL.
`default_nettype none

module fault_shunt_admittance_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fsa_pkg::*;

	localparam int FRAC = 32;
	localparam int RANDOM_ITEMS = 1600;
	// This gives a generous drain allowance.
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic signed [255:0] wide_t;

	// This class holds the expected admittances in order and checks each popped item.
	class admittance_scoreboard;
		out_item_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Rounds num/den half away from zero. The denominator is positive.
		// The quotient is then clamped to the 64-bit signed range.
		function logic [63:0] divide_round(wide_t num, wide_t den);
			logic neg;
			logic [255:0] mag, quo, rem;
			neg = num[255];
			mag = neg ? -num : num;
			quo = mag / den;
			rem = mag % den;
			if ((rem << 1) >= den)
				quo = quo + 1;
			if (neg) begin
				if (quo > 256'h8000_0000_0000_0000)
					return NEG_MAX;
				return -quo[63:0];
			end
			if (quo > 256'h7FFF_FFFF_FFFF_FFFF)
				return POS_MAX;
			return quo[63:0];
		endfunction

		function out_item_t shunt_admittance(in_item_t it);
			wide_t tr, ti, fr, fi, pr, pi, zr, zi, dr, di, qr, qi, den, nr, ni;
			logic sat;
			out_item_t y;
			tr = wide_t'(it.thevenin_real);
			ti = wide_t'(it.thevenin_imag);
			fr = wide_t'(it.fault_real);
			fi = wide_t'(it.fault_imag);
			sat = 1'b0;
			if (it.kind == KIND_DOUBLE_LG) begin
				// Y = D / (Zth*Z0 + Zf*D) keeps the parallel combination exact.
				pr = 2 * tr + 3 * fr;
				pi = 2 * ti + 3 * fi;
				zr = tr + 3 * fr;
				zi = ti + 3 * fi;
				sat = (pr == 0) && (pi == 0);
				dr = pr;
				di = pi;
				qr = (tr * zr - ti * zi) + (fr * pr - fi * pi);
				qi = (tr * zi + ti * zr) + (fr * pi + fi * pr);
			end else begin
				case (it.kind)
					KIND_THREE_PHASE: begin
						zr = fr;
						zi = fi;
					end
					KIND_LINE_GROUND: begin
						zr = 2 * tr + 3 * fr;
						zi = 2 * ti + 3 * fi;
					end
					default: begin
						zr = tr + fr;
						zi = ti + fi;
					end
				endcase
				dr = wide_t'(1) << FRAC;
				di = 0;
				qr = zr << FRAC;
				qi = zi << FRAC;
			end
			if (qr == 0 && qi == 0)
				sat = 1'b1;
			if (sat) begin
				y.admittance_real = 64'(SAT_UNITS) << FRAC;
				y.admittance_imag = '0;
				y.saturated = 1'b1;
			end else begin
				den = qr * qr + qi * qi;
				nr = (dr * qr + di * qi) << (2 * FRAC);
				ni = (di * qr - dr * qi) << (2 * FRAC);
				y.admittance_real = divide_round(nr, den);
				y.admittance_imag = divide_round(ni, den);
				y.saturated = 1'b0;
			end
			return y;
		endfunction

		function void note_request(in_item_t it);
			pending.push_back(shunt_admittance(it));
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$error("unexpected result item %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.admittance_real !== want.admittance_real) begin
				$error("admittance_real: expected %0d, got %0d",
					want.admittance_real, got.admittance_real);
				errors++;
			end
			if (got.admittance_imag !== want.admittance_imag) begin
				$error("admittance_imag: expected %0d, got %0d",
					want.admittance_imag, got.admittance_imag);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	in_item_t request = '0;
	out_item_t result;

	admittance_scoreboard sb = new();
	int cycles = 0;
	// While this flag is set, neither side idles. This gives one long busy stretch.
	logic steady = 1'b0;

	fault_shunt_admittance #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always #6 clk = ~clk;

	// The output side drops pop with a chance of about 31 percent. It pops every cycle during the busy stretch.
	always @(negedge clk) begin
		pop <= arst_n && (steady || $urandom_range(99) >= 31);
	end

	// A result item is taken at a rising edge when pop is high and empty is low.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(result);
	end

	// This watchdog catches a hang anywhere in the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// A Q15.32 operand mixes full-range bit patterns with small and near-zero values.
	// The small values keep most admittances in range. The full-range ones reach the clamps.
	function automatic logic signed [47:0] pick_operand();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2: return raw[47:0];
			3: return 48'(signed'(raw[15:0]));
			4: return '0;
			default: return 48'(signed'(raw[38:0]));
		endcase
	endfunction

	// This task offers one item at the falling edge and holds it until the block takes it.
	// Random idle cycles come before the offer.
	task automatic send_request(in_item_t it);
		while (!steady && $urandom_range(99) < 31) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		request <= it;
		do @(posedge clk); while (full);
		sb.note_request(it);
	endtask

	task automatic send_fault(logic [1:0] k, logic signed [47:0] tr,
			logic signed [47:0] ti, logic signed [47:0] fr, logic signed [47:0] fi);
		in_item_t it;
		it.kind = k;
		it.thevenin_real = tr;
		it.thevenin_imag = ti;
		it.fault_real = fr;
		it.fault_imag = fi;
		send_request(it);
	endtask

	// This task lowers push and waits until every expected result has been popped.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	localparam logic signed [47:0] ONE_PU = 48'sd1 << FRAC;
	localparam logic signed [47:0] MAXV = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MINV = 48'sh8000_0000_0000;

	initial begin
		in_item_t it;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: each kind with ordinary, extreme and degenerate impedances.
		send_fault(KIND_THREE_PHASE, ONE_PU, ONE_PU, ONE_PU / 10, ONE_PU);
		send_fault(KIND_LINE_GROUND, ONE_PU / 20, ONE_PU / 5, ONE_PU / 100, 0);
		send_fault(KIND_LINE_LINE, ONE_PU, -ONE_PU, ONE_PU, ONE_PU * 3);
		send_fault(KIND_DOUBLE_LG, ONE_PU / 50, ONE_PU / 4, ONE_PU / 10, ONE_PU / 7);
		// A zero fault impedance forces the saturated result for a three-phase fault.
		send_fault(KIND_THREE_PHASE, MAXV, MINV, 0, 0);
		// Here 2*Zth + 3*Zf cancels for a single line-ground fault.
		send_fault(KIND_LINE_GROUND, 3 * ONE_PU, -6, -2 * ONE_PU, 4);
		// Here Zth + Zf cancels for a line-line fault.
		send_fault(KIND_LINE_LINE, MAXV, MINV + 1, -MAXV, MAXV);
		// Here the parallel denominator is zero for a double line-ground fault.
		send_fault(KIND_DOUBLE_LG, -3 * ONE_PU, 9, 2 * ONE_PU, -6);
		send_fault(KIND_DOUBLE_LG, 0, 0, 0, 0);
		// A single-LSB impedance gives an admittance far outside the range, so the result clamps.
		send_fault(KIND_THREE_PHASE, 0, 0, 1, 0);
		send_fault(KIND_THREE_PHASE, 0, 0, -1, 0);
		send_fault(KIND_THREE_PHASE, 0, 0, 1, -1);
		send_fault(KIND_LINE_LINE, 0, 1, 0, 0);
		// Extreme operands in every field.
		send_fault(KIND_THREE_PHASE, MINV, MAXV, MAXV, MAXV);
		send_fault(KIND_THREE_PHASE, MAXV, MAXV, MINV, MINV);
		send_fault(KIND_LINE_GROUND, MAXV, MAXV, MAXV, MAXV);
		send_fault(KIND_LINE_GROUND, MINV, MINV, MINV, MINV);
		send_fault(KIND_LINE_LINE, MINV, MINV, MINV, MINV);
		send_fault(KIND_DOUBLE_LG, MAXV, MAXV, MAXV, MAXV);
		send_fault(KIND_DOUBLE_LG, MINV, MINV, MINV, MINV);
		send_fault(KIND_DOUBLE_LG, MAXV, MINV, MINV, MAXV);
		send_fault(KIND_DOUBLE_LG, 1, 0, 0, 1);

		// Random part. There is one pause for a full drain partway through.
		// A stretch with no idling follows it.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 700)
				drain();
			steady = (n >= 700 && n < 950);
			it.kind = 2'($urandom_range(3));
			it.thevenin_real = pick_operand();
			it.thevenin_imag = pick_operand();
			it.fault_real = pick_operand();
			it.fault_imag = pick_operand();
			// Some items are built to cancel so that the saturated path gets regular hits.
			if ($urandom_range(39) == 0) begin
				it.fault_real = -it.thevenin_real;
				it.fault_imag = -it.thevenin_imag;
				if (it.kind == KIND_DOUBLE_LG || it.kind == KIND_LINE_GROUND) begin
					it.thevenin_real = 3 * (it.thevenin_real >>> 4);
					it.thevenin_imag = 3 * (it.thevenin_imag >>> 4);
					it.fault_real = -2 * (it.thevenin_real / 3);
					it.fault_imag = -2 * (it.thevenin_imag / 3);
				end
			end
			send_request(it);
		end
		steady = 1'b0;

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/fsa_pkg.sv
rtl/fsa_fifo.sv
rtl/fsa_front.sv
rtl/fsa_mul.sv
rtl/fsa_back.sv
rtl/fault_shunt_admittance.sv
tb/fault_shunt_admittance_tb.sv
